// File: hdl/lesc_pkg.sv
// Shared types, codes and a character helper for the lambda expression syntax checker.
`timescale 1ns / 1ps

package lesc_pkg;

  localparam int unsigned      MAX_NESTING_DEF     = 255;
  localparam longint unsigned  MAX_TEXT_LENGTH_DEF = 64'd65535;

  localparam int unsigned POS_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Characters the scanner reacts to.
  localparam logic [7:0] CH_NUL         = 8'h00;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_DOT         = 8'h2E;
  localparam logic [7:0] CH_EQUAL       = 8'h3D;
  localparam logic [7:0] CH_BACKSLASH   = 8'h5C;
  localparam logic [7:0] CH_LPAREN      = 8'h28;
  localparam logic [7:0] CH_RPAREN      = 8'h29;
  localparam logic [7:0] CH_LAMBDA_LEAD = 8'hCE;
  localparam logic [7:0] CH_LAMBDA_TAIL = 8'hBB;

  typedef enum logic [2:0] {
    MODE_MAIN,
    MODE_LAMBDA2,
    MODE_ABS_SPACE,
    MODE_ABS_NAME,
    MODE_ABS_DOT,
    MODE_NAME,
    MODE_ASSIGN,
    MODE_ERROR
  } mode_t;

  typedef enum logic [1:0] {
    NAMING_NONE,
    NAMING_DONE,
    NAMING_UNKNOWN
  } naming_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_CHAR,
    ERR_ARG,
    ERR_DOT,
    ERR_EXPR,
    ERR_OP,
    ERR_PAREN
  } err_t;

  // Scanner state apart from the parenthesis depth, whose width is a parameter.
  typedef struct packed {
    mode_t            mode;
    naming_t          naming;
    logic             pending;
    logic [POS_W-1:0] idx;
    err_t             err;
    logic [POS_W-1:0] err_idx;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    mode:    MODE_MAIN,
    naming:  NAMING_UNKNOWN,
    pending: 1'b1,
    idx:     '0,
    err:     ERR_NONE,
    err_idx: '0
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } lesc_in_t;

  typedef struct packed {
    logic             syntax_ok;
    logic [2:0]       error_code;
    logic [POS_W-1:0] error_position;
  } lesc_out_t;

  function automatic logic is_name_byte(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

endpackage

// File: hdl/lesc_scan.sv
// Combinational next-state and verdict logic for one text byte.
`timescale 1ns / 1ps

module lesc_scan
  import lesc_pkg::*;
#(
  parameter int unsigned     MAX_NESTING     = MAX_NESTING_DEF,
  parameter longint unsigned MAX_TEXT_LENGTH = MAX_TEXT_LENGTH_DEF,
  localparam int unsigned    DEPTH_W         = $clog2(MAX_NESTING + 1)
) (
  input  lesc_in_t           item,
  input  ctl_t               cur_ctl,
  input  logic [DEPTH_W-1:0] cur_depth,
  output ctl_t               next_ctl,
  output logic [DEPTH_W-1:0] next_depth,
  output logic               has_result,
  output lesc_out_t          result
);

  typedef struct packed {
    ctl_t               ctl;
    logic [DEPTH_W-1:0] depth;
  } scan_t;

  function automatic scan_t fail(input scan_t s, input err_t code);
    scan_t r;
    r = s;
    r.ctl.err     = code;
    r.ctl.err_idx = s.ctl.idx;
    r.ctl.mode    = MODE_ERROR;
    return r;
  endfunction

  function automatic scan_t scan_main(input scan_t s, input logic [7:0] c);
    scan_t r;
    r = s;
    if (c == CH_SPACE) begin
      r = s;
    end else if (is_name_byte(c)) begin
      r.ctl.pending = 1'b0;
      r.ctl.mode    = MODE_NAME;
    end else begin
      case (c)
        CH_DOT, CH_EQUAL: r = fail(s, ERR_OP);
        CH_BACKSLASH:     r.ctl.mode = MODE_ABS_SPACE;
        CH_LAMBDA_LEAD:   r.ctl.mode = MODE_LAMBDA2;
        CH_RPAREN: begin
          if (s.depth == '0) begin
            r = fail(s, ERR_PAREN);
          end else begin
            r.depth = s.depth - DEPTH_W'(1);
            if (s.ctl.pending) r = fail(r, ERR_EXPR);
          end
        end
        CH_LPAREN: begin
          if (32'(s.depth) >= MAX_NESTING) begin
            r = fail(s, ERR_PAREN);
          end else begin
            r.depth = s.depth + DEPTH_W'(1);
            if (s.ctl.naming == NAMING_UNKNOWN) r.ctl.naming = NAMING_DONE;
          end
        end
        default: r = fail(s, ERR_CHAR);
      endcase
    end
    return r;
  endfunction

  function automatic scan_t check_assign(input scan_t s, input logic [7:0] c);
    scan_t r;
    r = s;
    if (c == CH_SPACE) begin
      r.ctl.mode = MODE_ASSIGN;
    end else if (c == CH_EQUAL) begin
      r.ctl.naming  = NAMING_DONE;
      r.ctl.pending = 1'b1;
      r.ctl.mode    = MODE_MAIN;
    end else begin
      r.ctl.naming = NAMING_NONE;
      r.ctl.mode   = MODE_MAIN;
      r = scan_main(r, c);
    end
    return r;
  endfunction

  function automatic scan_t scan_byte(input scan_t s, input logic [7:0] c);
    scan_t r;
    r = s;
    case (s.ctl.mode)
      MODE_MAIN: r = scan_main(s, c);
      MODE_LAMBDA2: begin
        if (c == CH_LAMBDA_TAIL) r.ctl.mode = MODE_ABS_SPACE;
        else r = fail(s, ERR_CHAR);
      end
      MODE_ABS_SPACE: begin
        if (c == CH_SPACE) r = s;
        else if (is_name_byte(c)) r.ctl.mode = MODE_ABS_NAME;
        else r = fail(s, ERR_ARG);
      end
      MODE_ABS_NAME, MODE_ABS_DOT: begin
        if (s.ctl.mode == MODE_ABS_NAME && is_name_byte(c)) begin
          r = s;
        end else if (c == CH_SPACE) begin
          r.ctl.mode = MODE_ABS_DOT;
        end else if (c == CH_DOT) begin
          r.ctl.pending = 1'b1;
          if (s.ctl.naming == NAMING_UNKNOWN) r.ctl.naming = NAMING_DONE;
          r.ctl.mode = MODE_MAIN;
        end else begin
          r = fail(s, ERR_DOT);
        end
      end
      MODE_NAME: begin
        if (is_name_byte(c)) begin
          r = s;
        end else if (s.ctl.naming != NAMING_UNKNOWN) begin
          r.ctl.mode = MODE_MAIN;
          r = scan_main(r, c);
        end else begin
          r = check_assign(s, c);
        end
      end
      MODE_ASSIGN: r = check_assign(s, c);
      default:     r = s;
    endcase
    return r;
  endfunction

  function automatic scan_t finish(input scan_t s);
    scan_t r;
    r = s;
    case (s.ctl.mode)
      MODE_ERROR:                  r = s;
      MODE_LAMBDA2:                r = fail(s, ERR_CHAR);
      MODE_ABS_SPACE:              r = fail(s, ERR_ARG);
      MODE_ABS_NAME, MODE_ABS_DOT: r = fail(s, ERR_DOT);
      default: begin
        if (s.depth != '0) r = fail(s, ERR_PAREN);
        else if (s.ctl.pending) r = fail(s, ERR_EXPR);
      end
    endcase
    return r;
  endfunction

  scan_t cur;
  scan_t fin;
  scan_t stepped;
  logic  is_end;
  logic  in_range;

  assign cur      = '{ctl: cur_ctl, depth: cur_depth};
  assign is_end   = item.end_of_text || (item.text_byte == CH_NUL);
  assign in_range = 33'(cur_ctl.idx) < 33'(MAX_TEXT_LENGTH);

  always_comb begin
    fin = finish(cur);
  end

  // Next state.
  always_comb begin
    stepped = cur;
    if (in_range && cur_ctl.mode != MODE_ERROR) stepped = scan_byte(cur, item.text_byte);
    if (cur_ctl.idx != POS_MAX) stepped.ctl.idx = cur_ctl.idx + POS_W'(1);
    if (is_end) begin
      next_ctl   = CTL_RESET;
      next_depth = '0;
    end else begin
      next_ctl   = stepped.ctl;
      next_depth = stepped.depth;
    end
  end

  // Verdict.
  always_comb begin
    has_result = is_end;
    if (fin.ctl.mode == MODE_ERROR) begin
      result.syntax_ok      = 1'b0;
      result.error_code     = fin.ctl.err;
      result.error_position = fin.ctl.err_idx;
    end else begin
      result.syntax_ok      = 1'b1;
      result.error_code     = ERR_NONE;
      result.error_position = '0;
    end
  end

endmodule

// File: hdl/lesc_out_reg.sv
// Output register holding one verdict until the downstream side takes it.
`timescale 1ns / 1ps

module lesc_out_reg
  import lesc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  lesc_out_t load_data,
  output logic      free,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output lesc_out_t rsp_data
);

  logic held;

  assign free      = !held || rsp_ready;
  assign rsp_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (rsp_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) rsp_data <= load_data;
  end

endmodule

// File: hdl/lambda_expression_syntax_checker_top.sv
// Top level of the lambda expression syntax checker: input register, scan state, verdict output.
`timescale 1ns / 1ps

// Channel   Ports                             Payload
// request   req_valid / req_ready / req_data  lesc_in_t: text_byte, end_of_text
// verdict   rsp_valid / rsp_ready / rsp_data  lesc_out_t: syntax_ok, error_code, error_position
//
// A request is scanned while it sits in the input register, so a byte is taken every cycle unless
// an ending request waits on a full verdict register; an ending request loads its verdict into the
// verdict register as it moves on, and rsp_valid rises once that register holds the verdict.
// Reset (rst, synchronous) empties both registers and puts the scanner in its start state.
// Only an ending request waits on a full verdict register; ordinary bytes never stall, and
// the input register keeps taking requests whenever the held one moves on in the same cycle.

module lambda_expression_syntax_checker_top
  import lesc_pkg::*;
#(
  parameter int unsigned     MAX_NESTING     = MAX_NESTING_DEF,
  parameter longint unsigned MAX_TEXT_LENGTH = MAX_TEXT_LENGTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  lesc_in_t  req_data,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output lesc_out_t rsp_data
);

  localparam int unsigned DEPTH_W = $clog2(MAX_NESTING + 1);

  // Input register stage.
  logic     stage_valid;
  lesc_in_t stage_item;

  // Scanner state: mode, naming status, pending flag, byte index and the first error.
  ctl_t               ctl;
  logic [DEPTH_W-1:0] depth;

  ctl_t               ctl_next;
  logic [DEPTH_W-1:0] depth_next;
  logic               has_result;
  lesc_out_t          verdict;
  logic               out_free;
  logic               stage_fire;

  // The held request moves on unless it ends a text and the verdict register is still full.
  assign stage_fire = stage_valid && (!has_result || out_free);
  assign req_ready  = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) stage_item <= req_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl   <= CTL_RESET;
      depth <= '0;
    end else if (stage_fire) begin
      ctl   <= ctl_next;
      depth <= depth_next;
    end
  end

  lesc_scan #(
    .MAX_NESTING     (MAX_NESTING),
    .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
  ) u_scan (
    .item       (stage_item),
    .cur_ctl    (ctl),
    .cur_depth  (depth),
    .next_ctl   (ctl_next),
    .next_depth (depth_next),
    .has_result (has_result),
    .result     (verdict)
  );

  lesc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (stage_fire && has_result),
    .load_data (verdict),
    .free      (out_free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  // After a verdict is issued the scanner must be back at its start state.
  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    (stage_fire && has_result) |=>
      (ctl.mode == MODE_MAIN && ctl.idx == '0 && depth == '0 && ctl.err == ERR_NONE))
    else $error("scanner state not cleared after a verdict");

  // A held error code exists exactly while the scanner sits in its error mode.
  a_error_consistent: assert property (@(posedge clk) disable iff (rst)
    (ctl.mode == MODE_ERROR) == (ctl.err != ERR_NONE))
    else $error("held error code disagrees with scan mode");

  // Parenthesis depth never exceeds the configured nesting limit.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= MAX_NESTING)
    else $error("parenthesis depth above its limit");

  // A passing verdict carries no error code and a zero position.
  a_pass_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.syntax_ok) |->
      (rsp_data.error_code == ERR_NONE && rsp_data.error_position == '0))
    else $error("passing verdict with error details");

  // An ordinary byte never blocks the input register.
  a_byte_no_stall: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !has_result) |-> req_ready)
    else $error("ordinary byte stalled the request side");

endmodule

// File: tb/sv/lambda_expression_syntax_checker_top_test.sv
// Self-checking testbench for the lambda expression syntax checker top level.
`timescale 1ns / 1ps

// The test streams expression texts into the checker one byte per request. It keeps its own
// copy of the scanner state and predicts the verdict that each ending request (a zero byte
// or the end_of_text flag) should produce. It compares every verdict that leaves the block,
// field by field, against the oldest prediction.
//
// The tests run in this order:
//   - short directed texts that cover each error code and the corner cases of the grammar,
//   - the nesting limit, both reached and exceeded,
//   - a long receiver hold-off while short texts keep coming, which fills the verdict
//     register and the input register so that the block stalls its input,
//   - random texts, first with idling on both sides and then with no idling at all.

module lambda_expression_syntax_checker_top_test;
  import lesc_pkg::*;

  // These limits match the parameters given to the instance below.
  localparam int unsigned NEST_LIMIT = 255;
  localparam int unsigned TEXT_LIMIT = 65535;
  localparam logic [15:0] LAST_INDEX = 16'hFFFF;

  // Number of cycles that the receiver refuses verdicts during the back-pressure test.
  localparam int unsigned HOLD_OFF_CYCLES = 100;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  lesc_in_t  req_data;
  logic      rsp_valid;
  logic      rsp_ready;
  lesc_out_t rsp_data;

  lambda_expression_syntax_checker_top #(
    .MAX_NESTING    (NEST_LIMIT),
    .MAX_TEXT_LENGTH(TEXT_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predicted scanner state. It mirrors what the block must hold between bytes.
  // ---------------------------------------------------------------------------------------
  mode_t       scan_mode_q;
  naming_t     naming_q;
  logic        expr_pending_q;
  logic [7:0]  depth_q;
  logic [15:0] pos_q;
  err_t        err_q;
  logic [15:0] err_pos_q;

  lesc_out_t   expected_verdicts[$];
  logic [7:0]  text_buf[$];

  bit idling_on;
  bit hold_off_pending;
  int failures;
  int requests_sent;
  int texts_sent;
  int verdicts_checked;
  int valid_verdicts;
  int stall_cycles;

  task automatic reset_model();
    scan_mode_q    = MODE_MAIN;
    naming_q       = NAMING_UNKNOWN;
    expr_pending_q = 1'b1;
    depth_q        = '0;
    pos_q          = '0;
    err_q          = ERR_NONE;
    err_pos_q      = '0;
  endtask

  function automatic bit name_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Only the first error counts. After it, the scanner sits in the error mode until the
  // text ends.
  task automatic raise_error(input err_t code);
    err_q       = code;
    err_pos_q   = pos_q;
    scan_mode_q = MODE_ERROR;
  endtask

  // A byte seen where a new term may start.
  task automatic scan_term(input logic [7:0] c);
    if (name_char(c)) begin
      expr_pending_q = 1'b0;
      scan_mode_q    = MODE_NAME;
    end else begin
      case (c)
        CH_SPACE: begin
        end
        CH_DOT, CH_EQUAL: raise_error(ERR_OP);
        CH_BACKSLASH: scan_mode_q = MODE_ABS_SPACE;
        CH_LAMBDA_LEAD: scan_mode_q = MODE_LAMBDA2;
        CH_RPAREN: begin
          if (depth_q == 0) begin
            raise_error(ERR_PAREN);
          end else begin
            depth_q = depth_q - 1'b1;
            if (expr_pending_q) raise_error(ERR_EXPR);
          end
        end
        CH_LPAREN: begin
          if (depth_q >= NEST_LIMIT) begin
            raise_error(ERR_PAREN);
          end else begin
            depth_q = depth_q + 1'b1;
            if (naming_q == NAMING_UNKNOWN) naming_q = NAMING_DONE;
          end
        end
        default: raise_error(ERR_CHAR);
      endcase
    end
  endtask

  // After a leading name, decide whether an assignment follows.
  task automatic resolve_binding(input logic [7:0] c);
    if (c == CH_SPACE) begin
      scan_mode_q = MODE_ASSIGN;
    end else if (c == CH_EQUAL) begin
      naming_q       = NAMING_DONE;
      expr_pending_q = 1'b1;
      scan_mode_q    = MODE_MAIN;
    end else begin
      naming_q    = NAMING_NONE;
      scan_mode_q = MODE_MAIN;
      scan_term(c);
    end
  endtask

  task automatic scan_byte(input logic [7:0] c);
    case (scan_mode_q)
      MODE_MAIN: scan_term(c);
      MODE_LAMBDA2: begin
        if (c == CH_LAMBDA_TAIL) scan_mode_q = MODE_ABS_SPACE;
        else raise_error(ERR_CHAR);
      end
      MODE_ABS_SPACE: begin
        if (c != CH_SPACE) begin
          if (name_char(c)) scan_mode_q = MODE_ABS_NAME;
          else raise_error(ERR_ARG);
        end
      end
      MODE_ABS_NAME, MODE_ABS_DOT: begin
        if (!(scan_mode_q == MODE_ABS_NAME && name_char(c))) begin
          if (c == CH_SPACE) begin
            scan_mode_q = MODE_ABS_DOT;
          end else if (c == CH_DOT) begin
            // The abstraction is complete, and a body must follow.
            expr_pending_q = 1'b1;
            if (naming_q == NAMING_UNKNOWN) naming_q = NAMING_DONE;
            scan_mode_q = MODE_MAIN;
          end else begin
            raise_error(ERR_DOT);
          end
        end
      end
      MODE_NAME: begin
        if (!name_char(c)) begin
          if (naming_q != NAMING_UNKNOWN) begin
            scan_mode_q = MODE_MAIN;
            scan_term(c);
          end else begin
            resolve_binding(c);
          end
        end
      end
      MODE_ASSIGN: resolve_binding(c);
      default: begin
      end
    endcase
  endtask

  // The text has ended. Settle any construct that is still open and queue the verdict.
  task automatic close_text();
    lesc_out_t verdict;
    case (scan_mode_q)
      MODE_ERROR: begin
      end
      MODE_LAMBDA2: raise_error(ERR_CHAR);
      MODE_ABS_SPACE: raise_error(ERR_ARG);
      MODE_ABS_NAME, MODE_ABS_DOT: raise_error(ERR_DOT);
      default: begin
        if (depth_q != 0) raise_error(ERR_PAREN);
        else if (expr_pending_q) raise_error(ERR_EXPR);
      end
    endcase
    if (scan_mode_q == MODE_ERROR) begin
      verdict.syntax_ok      = 1'b0;
      verdict.error_code     = err_q;
      verdict.error_position = err_pos_q;
    end else begin
      verdict.syntax_ok      = 1'b1;
      verdict.error_code     = ERR_NONE;
      verdict.error_position = '0;
    end
    expected_verdicts.push_back(verdict);
    reset_model();
  endtask

  task automatic predict_request(input logic [7:0] c, input logic eot);
    if (eot || c == CH_NUL) begin
      close_text();
    end else begin
      // Bytes past the scan window are counted but never looked at.
      if (pos_q < TEXT_LIMIT && scan_mode_q != MODE_ERROR) scan_byte(c);
      if (pos_q != LAST_INDEX) pos_q = pos_q + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Request side. Data changes at the falling edge. A request is taken at the first rising
  // edge with ready high, and the prediction is updated at that edge.
  // ---------------------------------------------------------------------------------------
  task automatic send_request(input logic [7:0] c, input logic eot);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 99) < 12) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= '{text_byte: c, end_of_text: eot};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    requests_sent++;
    predict_request(c, eot);
  endtask

  // Sends the text in text_buf and ends it with either the flag (any byte) or a zero byte.
  task automatic send_text(input bit flag_end);
    foreach (text_buf[i]) send_request(text_buf[i], 1'b0);
    if (flag_end) send_request(8'($urandom_range(0, 255)), 1'b1);
    else send_request(CH_NUL, 1'b0);
    texts_sent++;
  endtask

  task automatic try_text(input string s, input bit flag_end);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text(flag_end);
  endtask

  // ---------------------------------------------------------------------------------------
  // Verdict side. The receiver stalls at random, and on request it holds off for a long
  // stretch that it counts itself.
  // ---------------------------------------------------------------------------------------
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      rsp_ready <= !idling_on || ($urandom_range(0, 99) >= 14);
    end
  end

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      failures++;
      $display("%0t ns: verdict %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  lesc_out_t oldest_verdict;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_ready) stall_cycles++;
      if (rsp_valid && rsp_ready) begin
        if (expected_verdicts.size() == 0) begin
          failures++;
          $display("%0t ns: verdict with none expected: expected nothing, actual %0d/%0d/%0d",
                   $time, rsp_data.syntax_ok, rsp_data.error_code, rsp_data.error_position);
        end else begin
          oldest_verdict = expected_verdicts.pop_front();
          report_field("syntax_ok", oldest_verdict.syntax_ok, rsp_data.syntax_ok);
          report_field("error_code", oldest_verdict.error_code, rsp_data.error_code);
          report_field("error_position", oldest_verdict.error_position,
                       rsp_data.error_position);
          verdicts_checked++;
          if (rsp_data.syntax_ok) valid_verdicts++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Text generators.
  // ---------------------------------------------------------------------------------------
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 10))
      0: return CH_SPACE;
      1: return CH_DOT;
      2: return CH_EQUAL;
      3: return CH_BACKSLASH;
      4: return CH_LPAREN;
      5: return CH_RPAREN;
      6: return CH_LAMBDA_LEAD;
      7: return CH_LAMBDA_TAIL;
      8: return "a";
      9: return "7";
      default: return "Z";
    endcase
  endfunction

  task automatic put_spaces();
    if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 2)) text_buf.push_back(CH_SPACE);
  endtask

  task automatic put_name();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 2))
        0: text_buf.push_back(8'("0" + $urandom_range(0, 9)));
        1: text_buf.push_back(8'("A" + $urandom_range(0, 25)));
        default: text_buf.push_back(8'("a" + $urandom_range(0, 25)));
      endcase
    end
  endtask

  task automatic build_atom(input int level);
    int pick;
    pick = (level >= 3) ? 0 : $urandom_range(0, 5);
    case (pick)
      3: begin
        text_buf.push_back(CH_LPAREN);
        put_spaces();
        build_term(level + 1);
        put_spaces();
        text_buf.push_back(CH_RPAREN);
      end
      4, 5: begin
        if (pick == 4) begin
          text_buf.push_back(CH_BACKSLASH);
        end else begin
          text_buf.push_back(CH_LAMBDA_LEAD);
          text_buf.push_back(CH_LAMBDA_TAIL);
        end
        put_spaces();
        put_name();
        put_spaces();
        text_buf.push_back(CH_DOT);
        put_spaces();
        build_term(level + 1);
      end
      default: put_name();
    endcase
  endtask

  // An application of one to three atoms, sometimes followed by an empty pair of brackets.
  task automatic build_term(input int level);
    int atoms;
    atoms = $urandom_range(1, 3);
    for (int i = 0; i < atoms; i++) begin
      if (i > 0) text_buf.push_back(CH_SPACE);
      build_atom(level);
    end
    if ($urandom_range(0, 99) < 5) begin
      text_buf.push_back(CH_SPACE);
      text_buf.push_back(CH_LPAREN);
      text_buf.push_back(CH_RPAREN);
    end
  endtask

  task automatic build_expression();
    text_buf.delete();
    put_spaces();
    if ($urandom_range(0, 99) < 25) begin
      put_name();
      put_spaces();
      text_buf.push_back(CH_EQUAL);
      put_spaces();
    end
    build_term(0);
    put_spaces();
  endtask

  // Breaks a well-formed text: a byte replaced, dropped or added, or the tail cut off.
  task automatic damage_text();
    int idx;
    if (text_buf.size() != 0) begin
      idx = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: text_buf[idx] = noise_byte();
        1: text_buf.delete(idx);
        2: text_buf.insert(idx, noise_byte());
        default: while (text_buf.size() > idx) void'(text_buf.pop_back());
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------
  task automatic check_directed_texts();
    try_text("f = \\x.x y", 1'b1);      // assignment followed by an abstraction
    try_text("x ()", 1'b0);             // empty brackets after a term are accepted
    try_text("()", 1'b1);               // empty brackets at the start need an expression
    try_text(")", 1'b0);                // closing bracket with nothing open
    try_text("a.b", 1'b1);              // stray dot
    try_text("a = b = c", 1'b0);        // a second assignment is a stray operator
    try_text("x # y", 1'b1);            // bad character, the rest is ignored
    text_buf = '{8'hFF};
    send_text(1'b0);
    text_buf = '{CH_LAMBDA_TAIL};       // lone continuation byte
    send_text(1'b1);
    text_buf = '{CH_LAMBDA_LEAD, "q"};  // broken lambda pair
    send_text(1'b0);
    text_buf = '{CH_LAMBDA_LEAD};       // text ends inside the lambda pair
    send_text(1'b1);
    text_buf = '{CH_LAMBDA_LEAD, CH_LAMBDA_TAIL, "v", " ", ".", "v"};
    send_text(1'b0);
    try_text("\\ ", 1'b1);              // text ends before the argument name
    try_text("\\.", 1'b0);              // no argument name
    try_text("\\x y", 1'b1);            // no dot after the name
    try_text("(x", 1'b0);               // bracket left open
    try_text("", 1'b1);                 // empty text needs an expression
    try_text("(a) = b", 1'b0);          // assignment is only allowed up front
  endtask

  task automatic check_nesting_limit();
    // The deepest legal nesting, left open so that the end of the text reports it.
    text_buf.delete();
    repeat (NEST_LIMIT) text_buf.push_back(CH_LPAREN);
    text_buf.push_back("x");
    send_text(1'b1);
    // One more opening bracket than the block can count.
    text_buf.delete();
    repeat (NEST_LIMIT + 1) text_buf.push_back(CH_LPAREN);
    send_text(1'b0);
  endtask

  // Short texts keep arriving while verdicts are refused, so the input must stall.
  task automatic check_pressure_stall();
    hold_off_pending = 1'b1;
    repeat (24) try_text("x", 1'b0);
  endtask

  task automatic run_random_texts(input int request_budget);
    int first;
    int kind;
    first = requests_sent;
    while (requests_sent - first < request_budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        build_expression();
        if (kind >= 60) damage_text();
      end else begin
        text_buf.delete();
        repeat ($urandom_range(0, 12)) text_buf.push_back(noise_byte());
      end
      send_text($urandom_range(0, 1));
    end
  endtask

  initial begin
    rst              = 1'b1;
    req_valid        = 1'b0;
    req_data         = '0;
    idling_on        = 1'b1;
    hold_off_pending = 1'b0;
    failures         = 0;
    requests_sent    = 0;
    texts_sent       = 0;
    verdicts_checked = 0;
    valid_verdicts   = 0;
    stall_cycles     = 0;
    reset_model();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    check_directed_texts();
    check_nesting_limit();
    check_pressure_stall();
    run_random_texts(300);
    idling_on = 1'b0;
    run_random_texts(150);

    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d texts in %0d requests; checked %0d verdicts, %0d of them valid.",
             texts_sent, requests_sent, verdicts_checked, valid_verdicts);
    $display("Input was held back for %0d cycles; %0d mismatches were found.",
             stall_cycles, failures);
    if (failures == 0) begin
      $display("lambda_expression_syntax_checker_top regression: pass");
    end else begin
      $display("lambda_expression_syntax_checker_top regression: fail");
    end
    $finish;
  end

  // Hard time limit, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d verdicts still expected.", expected_verdicts.size());
    $display("lambda_expression_syntax_checker_top regression: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/lesc_pkg.sv
hdl/lesc_scan.sv
hdl/lesc_out_reg.sv
hdl/lambda_expression_syntax_checker_top.sv
tb/sv/lambda_expression_syntax_checker_top_test.sv
